/* hw/rtl/spi_pkg.sv */
// ----------------------------------------------------------------------------
// spi_pkg
// widths, register codes and word types shared by the segment/plane blocks
// ----------------------------------------------------------------------------
package spi_pkg;

  // coordinate and delta widths (q8.8 points, one extra bit for p2 - p1)
  localparam int unsigned CRD_W   = 16;
  localparam int unsigned DL_W    = 17;
  // normal times coordinate, plane distance, distance magnitude
  localparam int unsigned PRD_W   = 32;
  localparam int unsigned D_W     = 34;
  localparam int unsigned A_W     = 33;
  // divider: denominator, dividend, quotient, partial remainder
  localparam int unsigned UD_W    = 34;
  localparam int unsigned NUM_W   = 50;
  localparam int unsigned Q_W     = 17;
  localparam int unsigned REM_W   = 34;
  localparam int unsigned FRAC_W  = 16;
  // fraction times delta
  localparam int unsigned P_W     = 35;

  localparam int unsigned N_DIV_CELLS = Q_W;

  localparam logic [Q_W-1:0] U_ONE = {1'b1, {FRAC_W{1'b0}}};

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET = 2'd3;

  localparam logic signed [15:0] NORMAL_X_RST     = 16'sd0;
  localparam logic signed [15:0] NORMAL_Y_RST     = 16'sd0;
  localparam logic signed [15:0] NORMAL_Z_RST     = 16'sd16384;
  localparam logic signed [31:0] PLANE_OFFSET_RST = 32'sd0;

  typedef logic signed [CRD_W-1:0] coord_t;
  typedef logic signed [DL_W-1:0]  delta_t;

  // segment data that rides along with the division
  typedef struct packed {
    logic   hit;
    logic   in_plane;
    coord_t p1_x;
    coord_t p1_y;
    coord_t p1_z;
    delta_t dl_x;
    delta_t dl_y;
    delta_t dl_z;
  } carry_t;

  // restoring divider state handed from cell to cell
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   num;
    logic [UD_W-1:0]  den;
    logic [Q_W-1:0]   quo;
  } div_t;

endpackage

/* hw/rtl/spi_front.sv */
// ----------------------------------------------------------------------------
// spi_front
// plane distances of both endpoints, hit test and divider set-up
// ----------------------------------------------------------------------------
module spi_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic signed [15:0]   normal_x_i,
  input  logic signed [15:0]   normal_y_i,
  input  logic signed [15:0]   normal_z_i,
  input  logic signed [31:0]   plane_offset_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  spi_pkg::coord_t      start_x_i,
  input  spi_pkg::coord_t      start_y_i,
  input  spi_pkg::coord_t      start_z_i,
  input  spi_pkg::coord_t      end_x_i,
  input  spi_pkg::coord_t      end_y_i,
  input  spi_pkg::coord_t      end_z_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output spi_pkg::carry_t      carry_o,
  output spi_pkg::div_t        div_o
);

  logic [4:0] v_q;
  logic [4:0] rdy;

  assign rdy[4]  = !v_q[4] || ready_i;
  assign rdy[3]  = !v_q[3] || rdy[4];
  assign rdy[2]  = !v_q[2] || rdy[3];
  assign rdy[1]  = !v_q[1] || rdy[2];
  assign rdy[0]  = !v_q[0] || rdy[1];
  assign ready_o = rdy[0];
  assign valid_o = v_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
      if (rdy[4]) v_q[4] <= v_q[3];
    end
  end

  // stage 1: products of normal and coordinates, endpoint deltas
  logic signed [spi_pkg::PRD_W-1:0] m1x_q, m1y_q, m1z_q, m2x_q, m2y_q, m2z_q;
  spi_pkg::carry_t                  c1_d, c1_q;

  always_comb begin
    c1_d          = '0;
    c1_d.p1_x     = start_x_i;
    c1_d.p1_y     = start_y_i;
    c1_d.p1_z     = start_z_i;
    c1_d.dl_x     = $signed({end_x_i[15], end_x_i}) - $signed({start_x_i[15], start_x_i});
    c1_d.dl_y     = $signed({end_y_i[15], end_y_i}) - $signed({start_y_i[15], start_y_i});
    c1_d.dl_z     = $signed({end_z_i[15], end_z_i}) - $signed({start_z_i[15], start_z_i});
  end

  // stage 2: signed distances
  logic signed [spi_pkg::D_W-1:0] d1_d, d2_d, d1_q, d2_q;
  spi_pkg::carry_t                c2_q;

  always_comb begin
    d1_d = $signed({{2{m1x_q[31]}}, m1x_q}) + $signed({{2{m1y_q[31]}}, m1y_q})
         + $signed({{2{m1z_q[31]}}, m1z_q})
         + $signed({{2{plane_offset_i[31]}}, plane_offset_i});
    d2_d = $signed({{2{m2x_q[31]}}, m2x_q}) + $signed({{2{m2y_q[31]}}, m2y_q})
         + $signed({{2{m2z_q[31]}}, m2z_q})
         + $signed({{2{plane_offset_i[31]}}, plane_offset_i});
  end

  // stage 3: magnitudes and side test
  logic [spi_pkg::D_W-1:0] dn1, dn2;
  logic [spi_pkg::A_W-1:0] a1_d, a2_d, a1_q, a2_q;
  logic                    pos1, pos2, neg1, neg2;
  spi_pkg::carry_t         c3_d, c3_q;

  always_comb begin
    dn1  = -d1_q;
    dn2  = -d2_q;
    a1_d = d1_q[spi_pkg::D_W-1] ? dn1[spi_pkg::A_W-1:0] : d1_q[spi_pkg::A_W-1:0];
    a2_d = d2_q[spi_pkg::D_W-1] ? dn2[spi_pkg::A_W-1:0] : d2_q[spi_pkg::A_W-1:0];
    neg1 = d1_q[spi_pkg::D_W-1];
    neg2 = d2_q[spi_pkg::D_W-1];
    pos1 = !neg1 && (d1_q != '0);
    pos2 = !neg2 && (d2_q != '0);
    c3_d          = c2_q;
    c3_d.hit      = !((pos1 && pos2) || (neg1 && neg2));
    c3_d.in_plane = (d1_q == '0) && (d2_q == '0);
  end

  // stage 4: denominator |d1 - d2| = |d1| + |d2| on a hit
  logic [spi_pkg::A_W-1:0]  un_q;
  logic [spi_pkg::UD_W-1:0] ud_d, ud_q;
  spi_pkg::carry_t          c4_q;

  assign ud_d = {1'b0, a1_q} + {1'b0, a2_q};

  // stage 5: dividend |d1| * 2^16 + den / 2, first remainder
  logic [spi_pkg::NUM_W-1:0] num_full;
  spi_pkg::div_t             div_d, div_q;
  spi_pkg::carry_t           c5_q;

  always_comb begin
    num_full  = {1'b0, un_q, {spi_pkg::FRAC_W{1'b0}}}
              + {{(spi_pkg::NUM_W-spi_pkg::UD_W+1){1'b0}}, ud_q[spi_pkg::UD_W-1:1]};
    div_d.rem = {1'b0, num_full[spi_pkg::NUM_W-1:spi_pkg::Q_W]};
    div_d.num = num_full[spi_pkg::Q_W-1:0];
    div_d.den = ud_q;
    div_d.quo = '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      m1x_q <= normal_x_i * start_x_i;
      m1y_q <= normal_y_i * start_y_i;
      m1z_q <= normal_z_i * start_z_i;
      m2x_q <= normal_x_i * end_x_i;
      m2y_q <= normal_y_i * end_y_i;
      m2z_q <= normal_z_i * end_z_i;
      c1_q  <= c1_d;
    end
    if (rdy[1] && v_q[0]) begin
      d1_q <= d1_d;
      d2_q <= d2_d;
      c2_q <= c1_q;
    end
    if (rdy[2] && v_q[1]) begin
      a1_q <= a1_d;
      a2_q <= a2_d;
      c3_q <= c3_d;
    end
    if (rdy[3] && v_q[2]) begin
      un_q <= a1_q;
      ud_q <= ud_d;
      c4_q <= c3_q;
    end
    if (rdy[4] && v_q[3]) begin
      div_q <= div_d;
      c5_q  <= c4_q;
    end
  end

  assign carry_o = c5_q;
  assign div_o   = div_q;

endmodule

/* hw/rtl/spi_div_cell.sv */
// ----------------------------------------------------------------------------
// spi_div_cell
// one restoring-division cell, settles one quotient bit per word
// ----------------------------------------------------------------------------
module spi_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  spi_pkg::div_t   div_i,
  input  spi_pkg::carry_t carry_i,
  output logic            valid_o,
  input  logic            ready_i,
  output spi_pkg::div_t   div_o,
  output spi_pkg::carry_t carry_o
);

  logic                     valid_q;
  logic [spi_pkg::REM_W:0]  trial;
  logic [spi_pkg::REM_W:0]  diff;
  logic                     ge;
  spi_pkg::div_t            div_d, div_q;
  spi_pkg::carry_t          carry_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  // shift in the next dividend bit, subtract when the denominator fits
  always_comb begin
    trial     = {div_i.rem, div_i.num[spi_pkg::Q_W-1]};
    diff      = trial - {1'b0, div_i.den};
    ge        = trial >= {1'b0, div_i.den};
    div_d.rem = ge ? diff[spi_pkg::REM_W-1:0] : trial[spi_pkg::REM_W-1:0];
    div_d.num = {div_i.num[spi_pkg::Q_W-2:0], 1'b0};
    div_d.den = div_i.den;
    div_d.quo = {div_i.quo[spi_pkg::Q_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      div_q   <= div_d;
      carry_q <= carry_i;
    end
  end

  assign div_o   = div_q;
  assign carry_o = carry_q;

endmodule

/* hw/rtl/spi_back.sv */
// ----------------------------------------------------------------------------
// spi_back
// crossing point from the fraction, rounding, saturation and output register
// ----------------------------------------------------------------------------
module spi_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  spi_pkg::carry_t        carry_i,
  input  logic [spi_pkg::Q_W-1:0] quo_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic                   hit_o,
  output logic                   in_plane_o,
  output spi_pkg::coord_t        cross_x_o,
  output spi_pkg::coord_t        cross_y_o,
  output spi_pkg::coord_t        cross_z_o
);

  localparam logic signed [spi_pkg::P_W-1:0] RND_HALF = {{(spi_pkg::P_W-16){1'b0}}, 16'h8000};

  logic vm_q, vo_q;
  logic rdy_m, rdy_o;

  assign rdy_o   = !vo_q || ready_i;
  assign rdy_m   = !vm_q || rdy_o;
  assign ready_o = rdy_m;
  assign valid_o = vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy_m) vm_q <= valid_i;
      if (rdy_o) vo_q <= vm_q;
    end
  end

  // fraction times delta
  logic [spi_pkg::Q_W-1:0]          u;
  logic signed [spi_pkg::Q_W:0]     u_s;
  logic signed [spi_pkg::P_W-1:0]   px_d, py_d, pz_d, px_q, py_q, pz_q;
  spi_pkg::carry_t                  cm_q;

  always_comb begin
    u    = (quo_i > spi_pkg::U_ONE) ? spi_pkg::U_ONE : quo_i;
    u_s  = $signed({1'b0, u});
    px_d = u_s * carry_i.dl_x;
    py_d = u_s * carry_i.dl_y;
    pz_d = u_s * carry_i.dl_z;
  end

  // p1 + floor((prod + 2^15) / 2^16), clamped to q8.8
  function automatic spi_pkg::coord_t cross_coord(spi_pkg::coord_t p1,
                                                  logic signed [spi_pkg::P_W-1:0] prod);
    logic signed [spi_pkg::P_W-1:0] t;
    logic signed [18:0]             sh;
    logic signed [19:0]             sum;
    spi_pkg::coord_t                res;
    t   = prod + RND_HALF;
    sh  = $signed(t[spi_pkg::P_W-1:16]);
    sum = $signed({{4{p1[15]}}, p1}) + $signed({sh[18], sh});
    if (sum > 20'sd32767) begin
      res = 16'sh7fff;
    end else if (sum < -20'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = sum[15:0];
    end
    return res;
  endfunction

  spi_pkg::coord_t cx_d, cy_d, cz_d, cx_q, cy_q, cz_q;
  logic            hit_q, in_plane_q;

  always_comb begin
    if (!cm_q.hit) begin
      cx_d = '0;
      cy_d = '0;
      cz_d = '0;
    end else if (cm_q.in_plane) begin
      cx_d = cm_q.p1_x;
      cy_d = cm_q.p1_y;
      cz_d = cm_q.p1_z;
    end else begin
      cx_d = cross_coord(cm_q.p1_x, px_q);
      cy_d = cross_coord(cm_q.p1_y, py_q);
      cz_d = cross_coord(cm_q.p1_z, pz_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_m && valid_i) begin
      px_q <= px_d;
      py_q <= py_d;
      pz_q <= pz_d;
      cm_q <= carry_i;
    end
    if (rdy_o && vm_q) begin
      cx_q       <= cx_d;
      cy_q       <= cy_d;
      cz_q       <= cz_d;
      hit_q      <= cm_q.hit;
      in_plane_q <= cm_q.hit && cm_q.in_plane;
    end
  end

  assign hit_o      = hit_q;
  assign in_plane_o = in_plane_q;
  assign cross_x_o  = cx_q;
  assign cross_y_o  = cy_q;
  assign cross_z_o  = cz_q;

endmodule

/* hw/rtl/segment_plane_intersect.sv */
// registered path from an accepted input word to its result word
//   (5 front stages, 17 divider cells, 2 back stages)
// throughput: one word per cycle, limited by nothing but the output handshake
// every stage has its own valid bit, so input words keep flowing into bubbles
// reset clears all valid bits and loads the plane registers (normal = +z)
// ----------------------------------------------------------------------------
// segment_plane_intersect
// segment versus plane test with q8.8 crossing point
// ----------------------------------------------------------------------------
module segment_plane_intersect (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [spi_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [spi_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // segment input
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // start_x, start_y, start_z, end_x, end_y, end_z (16 bits each, lsb first)
  input  logic [95:0]                      s_axis_tdata_i,
  // crossing output
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // cross_x, cross_y, cross_z (16 bits each, lsb first)
  output logic [47:0]                      m_axis_tdata_o,
  // hit, in_plane
  output logic [1:0]                       m_axis_tuser_o
);

  localparam int unsigned NC = spi_pkg::N_DIV_CELLS;

  // plane registers; user writes only while the pipe is empty, not enforced
  logic signed [15:0] normal_x_q, normal_y_q, normal_z_q;
  logic signed [31:0] plane_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_x_q     <= spi_pkg::NORMAL_X_RST;
      normal_y_q     <= spi_pkg::NORMAL_Y_RST;
      normal_z_q     <= spi_pkg::NORMAL_Z_RST;
      plane_offset_q <= spi_pkg::PLANE_OFFSET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spi_pkg::REG_NORMAL_X:     normal_x_q     <= cfg_data_i[15:0];
        spi_pkg::REG_NORMAL_Y:     normal_y_q     <= cfg_data_i[15:0];
        spi_pkg::REG_NORMAL_Z:     normal_z_q     <= cfg_data_i[15:0];
        spi_pkg::REG_PLANE_OFFSET: plane_offset_q <= cfg_data_i;
      endcase
    end
  end

  // handshake and payload chain; index k feeds divider cell k
  logic [NC:0]     cv;
  logic [NC:0]     cr;
  spi_pkg::carry_t cc [NC+1];
  spi_pkg::div_t   cd [NC+1];

  // distances, side test and dividend set-up
  spi_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .normal_x_i     (normal_x_q),
    .normal_y_i     (normal_y_q),
    .normal_z_i     (normal_z_q),
    .plane_offset_i (plane_offset_q),
    .valid_i        (s_axis_tvalid_i),
    .ready_o        (s_axis_tready_o),
    .start_x_i      (s_axis_tdata_i[15:0]),
    .start_y_i      (s_axis_tdata_i[31:16]),
    .start_z_i      (s_axis_tdata_i[47:32]),
    .end_x_i        (s_axis_tdata_i[63:48]),
    .end_y_i        (s_axis_tdata_i[79:64]),
    .end_z_i        (s_axis_tdata_i[95:80]),
    .valid_o        (cv[0]),
    .ready_i        (cr[0]),
    .carry_o        (cc[0]),
    .div_o          (cd[0])
  );

  // row of divider cells, msb of the fraction first
  for (genvar k = 0; k < NC; k++) begin : g_div
    spi_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[k]),
      .ready_o (cr[k]),
      .div_i   (cd[k]),
      .carry_i (cc[k]),
      .valid_o (cv[k+1]),
      .ready_i (cr[k+1]),
      .div_o   (cd[k+1]),
      .carry_o (cc[k+1])
    );
  end

  // fraction times delta, rounding, clamp, output register
  spi_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (cv[NC]),
    .ready_o    (cr[NC]),
    .carry_i    (cc[NC]),
    .quo_i      (cd[NC].quo),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .hit_o      (m_axis_tuser_o[0]),
    .in_plane_o (m_axis_tuser_o[1]),
    .cross_x_o  (m_axis_tdata_o[15:0]),
    .cross_y_o  (m_axis_tdata_o[31:16]),
    .cross_z_o  (m_axis_tdata_o[47:32])
  );

  // an empty output register lets every stage move, so input is open
  a_open_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with an empty output register");

  // a segment lying in the plane always counts as a hit
  a_plane_is_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> m_axis_tuser_o[0])
    else $error("in_plane set without hit");

  // a miss carries an all-zero crossing point
  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tdata_o == '0))
    else $error("nonzero crossing point on a miss");

endmodule

/* bench/tb_segment_plane_intersect.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_plane_intersect
// self-checking bench for the segment versus plane intersection block
// segments go in over the input stream, each crossing word is checked field by
// field against a plane-distance and crossing-point predictor; plane registers
// are rewritten between phases while the pipe is empty; both stream sides idle
// at random, with full-rate stretches and one long output stall
// ----------------------------------------------------------------------------
module tb_segment_plane_intersect;

  // input word: start_x in the lowest bits, end_z in the highest
  typedef struct packed {
    spi_pkg::coord_t end_z;
    spi_pkg::coord_t end_y;
    spi_pkg::coord_t end_x;
    spi_pkg::coord_t start_z;
    spi_pkg::coord_t start_y;
    spi_pkg::coord_t start_x;
  } segment_t;

  // {tuser, tdata} of an output word: cross_x lowest, then hit, in_plane on top
  typedef struct packed {
    logic            in_plane;
    logic            hit;
    spi_pkg::coord_t cross_z;
    spi_pkg::coord_t cross_y;
    spi_pkg::coord_t cross_x;
  } crossing_t;

  localparam int HOLD_CYCLES = 300;

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           cfg_we_i        = 1'b0;
  logic [spi_pkg::CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [spi_pkg::CFG_DATA_W-1:0] cfg_data_i      = '0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  // start_x, start_y, start_z, end_x, end_y, end_z
  logic [95:0]                    s_axis_tdata_i  = '0;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  // cross_x, cross_y, cross_z
  logic [47:0]                    m_axis_tdata_o;
  // hit, in_plane
  logic [1:0]                     m_axis_tuser_o;

  // plane as the bench believes the block holds it
  logic signed [15:0] plane_nx  = spi_pkg::NORMAL_X_RST;
  logic signed [15:0] plane_ny  = spi_pkg::NORMAL_Y_RST;
  logic signed [15:0] plane_nz  = spi_pkg::NORMAL_Z_RST;
  logic signed [31:0] plane_off = spi_pkg::PLANE_OFFSET_RST;

  crossing_t pending_crossings[$];

  int idle_pct      = 22;
  logic rx_hold     = 1'b0;
  int err_count     = 0;
  int segs_sent     = 0;
  int words_checked = 0;
  int hits_seen     = 0;
  int in_plane_seen = 0;
  int planes_set    = 0;

  segment_plane_intersect i_dut (.*);

  always #10 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // signed distance n.P + offset, 22 fraction bits, held exactly
  function automatic longint plane_distance(spi_pkg::coord_t x, spi_pkg::coord_t y,
                                            spi_pkg::coord_t z);
    return longint'(plane_nx) * x + longint'(plane_ny) * y + longint'(plane_nz) * z
           + longint'(plane_off);
  endfunction

  function automatic spi_pkg::coord_t crossing_coord(longint frac, spi_pkg::coord_t a,
                                                     spi_pkg::coord_t b);
    longint delta;
    longint t;
    longint c;
    delta = longint'(b) - longint'(a);
    // rounded half up, floor of the shifted sum
    t = frac * delta + 32768;
    c = longint'(a) + (t >>> 16);
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    return spi_pkg::coord_t'(c[15:0]);
  endfunction

  function automatic crossing_t predict_crossing(segment_t seg);
    crossing_t r;
    longint d1;
    longint d2;
    longint num;
    longint den;
    longint frac;
    r  = '0;
    d1 = plane_distance(seg.start_x, seg.start_y, seg.start_z);
    d2 = plane_distance(seg.end_x, seg.end_y, seg.end_z);
    // both strictly on one side: no hit, everything zero
    if ((d1 > 0 && d2 > 0) || (d1 < 0 && d2 < 0)) return r;
    r.hit = 1'b1;
    if (d1 == 0 && d2 == 0) begin
      // segment lies in the plane, report its start point
      r.in_plane = 1'b1;
      r.cross_x  = seg.start_x;
      r.cross_y  = seg.start_y;
      r.cross_z  = seg.start_z;
      return r;
    end
    num  = (d1 < 0) ? -d1 : d1;
    den  = (d1 - d2 < 0) ? d2 - d1 : d1 - d2;
    frac = (num * 65536 + den / 2) / den;
    if (frac > 65536) frac = 65536;
    r.cross_x = crossing_coord(frac, seg.start_x, seg.end_x);
    r.cross_y = crossing_coord(frac, seg.start_y, seg.end_y);
    r.cross_z = crossing_coord(frac, seg.start_z, seg.end_z);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what, longint got, longint want);
    err_count++;
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  task automatic check_crossing(crossing_t got);
    crossing_t want;
    if (pending_crossings.size() == 0) begin
      report_mismatch("unexpected word", got, 0);
      return;
    end
    want = pending_crossings.pop_front();
    words_checked++;
    if (got.hit) hits_seen++;
    if (got.in_plane) in_plane_seen++;
    if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
    if (got.in_plane !== want.in_plane)
      report_mismatch("in_plane", got.in_plane, want.in_plane);
    if (got.cross_x !== want.cross_x) report_mismatch("cross_x", got.cross_x, want.cross_x);
    if (got.cross_y !== want.cross_y) report_mismatch("cross_y", got.cross_y, want.cross_y);
    if (got.cross_z !== want.cross_z) report_mismatch("cross_z", got.cross_z, want.cross_z);
  endtask

  // output side: check the word taken at this edge, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      check_crossing({m_axis_tuser_o, m_axis_tdata_o});
    if (rx_hold)
      m_axis_tready_i <= 1'b0;
    else
      m_axis_tready_i <= ($urandom_range(99) >= idle_pct);
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  task automatic send_segment(segment_t seg);
    // random gaps ahead of the word
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= seg;
    do @(posedge clk_i); while (!s_axis_tready_o);
    // config only changes while idle, so the current plane applies
    pending_crossings.push_back(predict_crossing(seg));
    segs_sent++;
  endtask

  // stop sending and let every outstanding crossing come back
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_crossings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [spi_pkg::CFG_IDX_W-1:0]  idx,
                           logic [spi_pkg::CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  // rewrites all four plane registers back to back
  task automatic apply_plane(int nx, int ny, int nz, longint off);
    wait_idle();
    // upper bits of the normal words carry junk, only the low 16 count
    write_reg(spi_pkg::REG_NORMAL_X, {16'($urandom), nx[15:0]});
    write_reg(spi_pkg::REG_NORMAL_Y, {16'($urandom), ny[15:0]});
    write_reg(spi_pkg::REG_NORMAL_Z, {16'($urandom), nz[15:0]});
    write_reg(spi_pkg::REG_PLANE_OFFSET, off[31:0]);
    cfg_we_i  <= 1'b0;
    plane_nx  = nx[15:0];
    plane_ny  = ny[15:0];
    plane_nz  = nz[15:0];
    plane_off = off[31:0];
    planes_set++;
  endtask

  function automatic segment_t seg_of(int sx, int sy, int sz, int ex, int ey, int ez);
    segment_t s;
    s = {ez[15:0], ey[15:0], ex[15:0], sz[15:0], sy[15:0], sx[15:0]};
    return s;
  endfunction

  // coordinates biased toward the range ends and toward zero
  function automatic spi_pkg::coord_t rand_coord();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      3:       return 16'(int'($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int rand_normal();
    case ($urandom_range(9))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      default: return int'($urandom_range(32768)) - 16384;
    endcase
  endfunction

  // redraws a few times to land on the wanted side of the hit test
  function automatic segment_t rand_segment(logic want_hit);
    segment_t  s;
    crossing_t r;
    for (int n = 0; n < 16; n++) begin
      s = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
           rand_coord()};
      r = predict_crossing(s);
      if (r.hit == want_hit) break;
    end
    return s;
  endfunction

  // mostly crossing segments; with a plane of constant z, some endpoints on it
  task automatic random_batch(int count, logic z_plane, spi_pkg::coord_t z_level);
    segment_t s;
    int       pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        s = rand_segment(1'b1);
      end else if (pick < 82 || !z_plane) begin
        s = rand_segment(1'($urandom));
      end else begin
        s = rand_segment(1'($urandom));
        case ($urandom_range(2))
          0:       s.start_z = z_level;
          1:       s.end_z = z_level;
          default: begin
            s.start_z = z_level;
            s.end_z   = z_level;
          end
        endcase
      end
      send_segment(s);
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset plane is z = 0 with normal +z
  task automatic test_reset_plane();
    send_segment(seg_of(0, 0, 256, 100, -100, 512));              // both above
    send_segment(seg_of(7, -9, -256, 100, -100, -1));             // both below
    send_segment(seg_of(-1, -1, -1, -1, -1, -1));                 // all ones, below
    send_segment(seg_of(256, 512, -256, -256, 1024, 256));        // half way
    send_segment(seg_of(300, -400, 0, 10, 20, 700));              // start on plane
    send_segment(seg_of(5, 6, -900, -700, 800, 0));               // end on plane
    send_segment(seg_of(-32768, 32767, 0, 32767, -32768, 0));     // in plane
    send_segment(seg_of(-32768, -32768, -32768, 32767, 32767, 32767));
    send_segment(seg_of(32767, 32767, 32767, -32768, -32768, -32768));
    send_segment(seg_of(-32768, 32767, -1, 32767, -32768, 1));    // rounding at .5
    send_segment(seg_of(0, 3, -3, 3, 0, 1));                      // u of 0.75
    send_segment(seg_of(32767, -32768, -32768, 32767, -32768, 32767));
  endtask

  // diagonal plane x - y = -1.0 through 11585 ~ 1/sqrt(2)
  task automatic test_tilted_plane();
    apply_plane(11585, -11585, 0, 64'sd11585 * 256);
    send_segment(seg_of(0, 256, 77, 1000, 1256, -5000));         // in plane
    send_segment(seg_of(0, 0, 0, 1024, 0, 0));                    // same side
    send_segment(seg_of(-2000, 0, 40, 0, -2000, -40));            // crossing
    send_segment(seg_of(-32768, 32767, 0, 32767, -32768, 0));     // long diagonal
    send_segment(seg_of(0, 256, 0, 500, -500, 500));              // start on plane
  endtask

  // extreme register values in both directions
  task automatic test_register_extremes();
    apply_plane(-32768, 32767, -32768, -64'sd2147483648);
    random_batch(50, 1'b0, '0);
    apply_plane(32767, -32768, 32767, 64'sd2147483647);
    random_batch(50, 1'b0, '0);
  endtask

  task automatic test_random_planes();
    int     z0;
    int     nz;
    longint off;
    for (int k = 0; k < 7; k++) begin
      if (k < 2) begin
        // horizontal plane at height z0, normal up then down
        z0  = int'($urandom_range(4096)) - 2048;
        nz  = (k == 0) ? 16384 : -16384;
        off = -longint'(nz) * z0;
        apply_plane(0, 0, nz, off);
        random_batch(125, 1'b1, spi_pkg::coord_t'(z0));
      end else begin
        if (k == 6)
          off = longint'(int'($urandom));
        else
          off = longint'($urandom_range(1 << 28)) - (1 << 27);
        apply_plane(rand_normal(), rand_normal(), rand_normal(), off);
        // one plane runs at full rate on both sides
        if (k == 2) idle_pct = 0;
        random_batch(125, 1'b0, '0);
        idle_pct = 22;
      end
    end
  endtask

  // output held off long enough for the pipe to fill and stall the input
  task automatic test_backpressure();
    apply_plane(0, 0, 16384, 0);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    join_none
    idle_pct = 0;
    random_batch(80, 1'b1, '0);
    idle_pct = 22;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_plane();
    test_tilted_plane();
    test_register_extremes();
    test_random_planes();
    test_backpressure();

    wait_idle();
    // keep the clock running to catch stray words
    repeat (40) @(posedge clk_i);
    if (pending_crossings.size() != 0)
      report_mismatch("words still missing", pending_crossings.size(), 0);

    $display("%0d segments over %0d planes, %0d words checked", segs_sent, planes_set,
             words_checked);
    $display("%0d hits, %0d in plane, %0d mismatches", hits_seen, in_plane_seen, err_count);
    if (err_count == 0) begin
      $display("[segment_plane_intersect] OK");
    end else begin
      $display("[segment_plane_intersect] ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5ms;
    $display("timeout with %0d words outstanding", pending_crossings.size());
    $display("[segment_plane_intersect] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/spi_pkg.sv
hw/rtl/spi_front.sv
hw/rtl/spi_div_cell.sv
hw/rtl/spi_back.sv
hw/rtl/segment_plane_intersect.sv
bench/tb_segment_plane_intersect.sv
